// ===== src/dee_pkg.sv =====
// Shared types and register codes of the data EEPROM controller.
package dee_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] reg_sel_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] phase_t;

  localparam opcode_t OP_READ  = 2'd0;
  localparam opcode_t OP_WRITE = 2'd1;
  localparam opcode_t OP_TICK  = 2'd2;

  localparam reg_sel_t REG_ADDR   = 2'd0;
  localparam reg_sel_t REG_DATA   = 2'd1;
  localparam reg_sel_t REG_CTRL   = 2'd2;
  localparam reg_sel_t REG_UNLOCK = 2'd3;

  localparam phase_t PHASE_IDLE   = 2'd0;
  localparam phase_t PHASE_FIRST  = 2'd1;
  localparam phase_t PHASE_SECOND = 2'd2;

  localparam byte_t UNLOCK_FIRST  = 8'h55;
  localparam byte_t UNLOCK_SECOND = 8'hAA;
  localparam byte_t ERASED_BYTE   = 8'hFF;

  // Control register bit positions as seen on the bus.
  localparam int CTRL_RD   = 0;
  localparam int CTRL_WR   = 1;
  localparam int CTRL_WREN = 2;
  localparam int CTRL_SEL  = 7;

  localparam logic [15:0] WRITE_TICKS_RESET = 16'd1000;

endpackage

// ===== src/data_eeprom_controller.sv =====
// Data EEPROM controller: bus registers, unlock sequence, write timer and byte store.
//
//   channel   direction  handshake              payload
//   in        to block   in_valid / in_stall    opcode, reg_sel, write_data
//   out       from block out_valid / out_stall  read_data, write_busy
//   cfg       to block   cfg_write_en           cfg_write_data (write_ticks)
//
// One item per cycle while in_stall is low, one result per item, registered on acceptance.
// The store is read into a register at the next address register value, with the
// finishing byte write forwarded, so a control read uses a settled byte at once.
// Reset clears the per-byte valid flags in the same cycle; no clearing pass.
// A two-entry output buffer lets one item enter while a result waits; in_stall
// rises only when both entries are full.
module data_eeprom_controller #(
  parameter int MEM_DEPTH   = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dee_pkg::opcode_t  opcode,
  input  dee_pkg::reg_sel_t reg_sel,
  input  dee_pkg::byte_t    write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dee_pkg::byte_t    read_data,
  output logic              write_busy,
  input  logic              cfg_write_en,
  input  logic [15:0]       cfg_write_data
);
  import dee_pkg::*;

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [EW-1:0] CNT_MAX = EW'({COUNT_WIDTH{1'b1}});
  localparam logic [8:0] DEPTH_LIM = 9'(MEM_DEPTH);

  // architectural registers
  logic [15:0]            write_ticks;
  byte_t                  addr_reg, addr_next;
  byte_t                  data_reg, data_next;
  logic                   ctrl_wren, ctrl_wren_next;
  logic                   ctrl_sel, ctrl_sel_next;
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] busy_count, busy_next;
  byte_t                  pending_addr, pending_addr_next;
  byte_t                  pending_byte, pending_byte_next;

  // store and its read path
  byte_t                  mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]   mem_vld;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  byte_t                  mem_q;
  logic                   vld_q, byp_q, inr_q;
  byte_t                  byp_data_q;
  byte_t                  store_byte;

  // output buffer
  logic                   main_valid, skid_valid;
  byte_t                  main_rd, skid_rd;
  logic                   main_busy, skid_busy;
  logic                   accept, out_take;
  byte_t                  res_rd;
  logic                   res_busy;

  logic [EW-1:0]          ticks_ext;
  logic [COUNT_WIDTH-1:0] start_cnt;
  logic                   start_ok;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  assign out_valid  = main_valid;
  assign read_data  = main_rd;
  assign write_busy = main_busy;

  // clamp the configured tick count to 1..counter maximum
  always_comb begin
    ticks_ext = EW'(write_ticks);
    if (write_ticks == 16'd0) begin
      start_cnt = COUNT_WIDTH'(1);
    end else if (ticks_ext > CNT_MAX) begin
      start_cnt = CNT_MAX[COUNT_WIDTH-1:0];
    end else begin
      start_cnt = ticks_ext[COUNT_WIDTH-1:0];
    end
  end

  // byte at addr_reg as the store holds it now
  always_comb begin
    if (!inr_q) begin
      store_byte = ERASED_BYTE;
    end else if (byp_q) begin
      store_byte = byp_data_q;
    end else if (vld_q) begin
      store_byte = mem_q;
    end else begin
      store_byte = ERASED_BYTE;
    end
  end

  always_comb begin
    addr_next         = addr_reg;
    data_next         = data_reg;
    ctrl_wren_next    = ctrl_wren;
    ctrl_sel_next     = ctrl_sel;
    phase_next        = phase;
    busy_next         = busy_count;
    pending_addr_next = pending_addr;
    pending_byte_next = pending_byte;
    mem_we            = 1'b0;
    res_rd            = '0;
    start_ok          = 1'b0;
    if (accept) begin
      case (opcode)
        OP_READ: begin
          case (reg_sel)
            REG_ADDR: res_rd = addr_reg;
            REG_DATA: res_rd = data_reg;
            REG_CTRL: begin
              res_rd[CTRL_WR]   = (busy_count != '0);
              res_rd[CTRL_WREN] = ctrl_wren;
              res_rd[CTRL_SEL]  = ctrl_sel;
            end
            default: res_rd = '0;
          endcase
        end
        OP_WRITE: begin
          case (reg_sel)
            REG_ADDR: addr_next = write_data;
            REG_DATA: data_next = write_data;
            REG_CTRL: begin
              ctrl_wren_next = write_data[CTRL_WREN];
              ctrl_sel_next  = write_data[CTRL_SEL];
              phase_next     = PHASE_IDLE;
              if (write_data[CTRL_RD] && !write_data[CTRL_SEL]) begin
                data_next = store_byte;
              end
              start_ok = write_data[CTRL_WR] && !write_data[CTRL_SEL] && ctrl_wren
                         && (phase == PHASE_SECOND) && (busy_count == '0);
              if (start_ok) begin
                pending_addr_next = addr_reg;
                pending_byte_next = data_next;
                busy_next         = start_cnt;
              end
            end
            default: begin
              if (write_data == UNLOCK_FIRST) begin
                phase_next = PHASE_FIRST;
              end else if (write_data == UNLOCK_SECOND && phase == PHASE_FIRST) begin
                phase_next = PHASE_SECOND;
              end else begin
                phase_next = PHASE_IDLE;
              end
            end
          endcase
        end
        OP_TICK: begin
          if (busy_count != '0) begin
            busy_next = busy_count - COUNT_WIDTH'(1);
            // store on the last tick; drop bytes beyond the store
            if (busy_count == COUNT_WIDTH'(1) && {1'b0, pending_addr} < DEPTH_LIM) begin
              mem_we = 1'b1;
            end
          end
        end
        default: res_rd = '0;
      endcase
    end
  end

  assign res_busy  = (busy_next != '0);
  assign mem_waddr = pending_addr[AW-1:0];
  assign mem_raddr = addr_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= pending_byte;
    end
    mem_q      <= mem[mem_raddr];
    byp_data_q <= pending_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      vld_q   <= 1'b0;
      byp_q   <= 1'b0;
      inr_q   <= 1'b1;
    end else begin
      if (mem_we) begin
        mem_vld[mem_waddr] <= 1'b1;
      end
      vld_q <= mem_vld[mem_raddr];
      byp_q <= mem_we && (mem_waddr == mem_raddr);
      inr_q <= ({1'b0, addr_next} < DEPTH_LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ticks  <= WRITE_TICKS_RESET;
      addr_reg     <= '0;
      data_reg     <= '0;
      ctrl_wren    <= 1'b0;
      ctrl_sel     <= 1'b0;
      phase        <= PHASE_IDLE;
      busy_count   <= '0;
      pending_addr <= '0;
      pending_byte <= '0;
    end else begin
      if (cfg_write_en) begin
        write_ticks <= cfg_write_data;
      end
      addr_reg     <= addr_next;
      data_reg     <= data_next;
      ctrl_wren    <= ctrl_wren_next;
      ctrl_sel     <= ctrl_sel_next;
      phase        <= phase_next;
      busy_count   <= busy_next;
      pending_addr <= pending_addr_next;
      pending_byte <= pending_byte_next;
    end
  end

  // output buffer: main register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (main_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end else if (out_take) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        main_rd   <= skid_rd;
        main_busy <= skid_busy;
      end
    end else if (accept) begin
      if (main_valid && !out_take) begin
        skid_rd   <= res_rd;
        skid_busy <= res_busy;
      end else begin
        main_rd   <= res_rd;
        main_busy <= res_busy;
      end
    end
  end

endmodule
